@@ rtl/lpht_pkg.sv @@
`default_nettype none
package lpht_pkg;

   localparam int TABLE_BITS  = 10;
   localparam int KEY_BYTES   = 4;
   localparam int VALUE_BITS  = 32;
   localparam int CAP         = 1 << TABLE_BITS;
   localparam int MAX_ENTRIES = (CAP >> 1) + (CAP >> 2);
   localparam int COUNT_W     = TABLE_BITS + 1;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] FIB_MULT  = 32'd2654435769;

   localparam logic [31:0] KEY_MASK =
      (KEY_BYTES >= 4) ? 32'hffff_ffff : 32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
   localparam logic [31:0] VALUE_MASK =
      (VALUE_BITS >= 32) ? 32'hffff_ffff : 32'((64'd1 << VALUE_BITS) - 64'd1);

   typedef logic [TABLE_BITS-1:0] slot_type;

   // request actions
   localparam logic [2:0] ACT_LOOKUP = 3'd0;
   localparam logic [2:0] ACT_INSERT = 3'd1;
   localparam logic [2:0] ACT_DELETE = 3'd2;
   localparam logic [2:0] ACT_WRITE  = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   // response status codes
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   // datapath operations
   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_SWEEP      = 5'd2;
   localparam logic [4:0] OP_HASH_KEY   = 5'd3;
   localparam logic [4:0] OP_HASH_Q     = 5'd4;
   localparam logic [4:0] OP_PROBE_INIT = 5'd5;
   localparam logic [4:0] OP_RD_I       = 5'd6;
   localparam logic [4:0] OP_RD_J       = 5'd7;
   localparam logic [4:0] OP_PROBE_NEXT = 5'd8;
   localparam logic [4:0] OP_HIT        = 5'd9;
   localparam logic [4:0] OP_NOT_FOUND  = 5'd10;
   localparam logic [4:0] OP_FULL       = 5'd11;
   localparam logic [4:0] OP_INSERT     = 5'd12;
   localparam logic [4:0] OP_WRITE_VAL  = 5'd13;
   localparam logic [4:0] OP_DEL_INIT   = 5'd14;
   localparam logic [4:0] OP_DEL_STEP   = 5'd15;
   localparam logic [4:0] OP_DEL_END    = 5'd16;
   localparam logic [4:0] OP_DONE       = 5'd17;
   localparam logic [4:0] OP_OUT        = 5'd18;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       hash_done;
      logic       used_q;
      logic       key_eq;
      logic       at_limit;
      logic       walk_end;
      logic       shift_end;
      logic       slot_bad;
      logic       sweep_last;
      logic       out_free;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/lpht_hash.sv @@
`default_nettype none
module lpht_hash
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] hash_key,
   output logic             done,
   output slot_type         home
);

   localparam int STEP_W = $clog2(KEY_BYTES + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       sh_ff, sh_in;
   logic [31:0]       h_ff, h_in;
   logic [31:0]       mul_a;

   // One FNV-1a byte round per cycle, then the Fibonacci multiply.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sh_in   = sh_ff;
      h_in    = h_ff;
      mul_a   = h_ff ^ {24'd0, sh_ff[7:0]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         sh_in   = hash_key;
         h_in    = FNV_BASIS;
      end else if (busy_ff) begin
         if (step_ff == STEP_W'(KEY_BYTES)) begin
            h_in    = h_ff * FIB_MULT;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            h_in    = mul_a * FNV_PRIME;
            sh_in   = sh_ff >> 8;
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      sh_ff   <= sh_in;
      h_ff    <= h_in;
   end

   assign done = done_ff;
   assign home = h_ff[31 -: TABLE_BITS];

endmodule
`default_nettype wire

@@ rtl/lpht_datapath.sv @@
`default_nettype none
module lpht_datapath
   import lpht_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output sts_type          sts,
   input  wire logic [2:0]   req_action,
   input  wire logic [31:0]  req_key,
   input  wire logic [9:0]   req_slot,
   input  wire logic [31:0]  req_value,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [10:0]       rsp_slot_out,
   output logic [31:0]       rsp_value_out,
   output logic [10:0]       rsp_entry_count_out
);

   logic [2:0]         act_ff, act_in;
   logic [31:0]        key_ff, key_in;
   logic [9:0]         slot_ff, slot_in;
   logic [31:0]        val_ff, val_in;
   slot_type           i_ff, i_in, j_ff, j_in, n_ff, n_in, sweep_ff, sweep_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [10:0]        res_slot_ff, res_slot_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff;
   logic [10:0]        rsp_slot_ff;
   logic [31:0]        rsp_value_ff;
   logic [10:0]        rsp_count_ff;

   logic               used_ff [CAP];
   logic [31:0]        keys_ff [CAP];
   logic [31:0]        vals_ff [CAP];
   logic               used_q_ff;
   logic [31:0]        key_q_ff, val_q_ff;

   logic               hash_start, hash_done;
   logic [31:0]        hash_key;
   slot_type           home;
   logic               move;
   slot_type           i_after, j_after;
   logic               used_we, used_wd, keys_we, vals_we, rd_en;
   slot_type           used_wa, rd_a;
   logic [31:0]        keys_wd, vals_wd;

   lpht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .hash_key (hash_key),
      .done     (hash_done),
      .home     (home)
   );

   assign hash_start = (cmd.op == OP_HASH_KEY) || (cmd.op == OP_HASH_Q);
   assign hash_key   = (cmd.op == OP_HASH_Q) ? key_q_ff : key_ff;

   // Backward shift: the entry at j may fill the gap at i unless its home lies
   // cyclically in (i, j].
   always_comb begin
      move    = ((j_ff > i_ff) && ((home <= i_ff) || (home > j_ff))) ||
                ((j_ff < i_ff) && ((home <= i_ff) && (home > j_ff)));
      i_after = move ? j_ff : i_ff;
      j_after = j_ff + 1'b1;
   end

   always_comb begin
      act_in        = act_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      val_in        = val_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      case (cmd.op)
         OP_LOAD: begin
            act_in   = req_action;
            key_in   = req_key & KEY_MASK;
            slot_in  = req_slot;
            val_in   = req_value & VALUE_MASK;
            i_in     = slot_type'(req_slot);
            sweep_in = '0;
         end
         OP_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            count_in = '0;
         end
         OP_PROBE_INIT: begin
            i_in = home;
            n_in = '0;
         end
         OP_PROBE_NEXT: begin
            i_in = i_ff + 1'b1;
            n_in = n_ff + 1'b1;
         end
         OP_HIT: begin
            res_status_in = ST_FOUND;
            res_slot_in   = 11'(i_ff);
            res_value_in  = val_q_ff;
         end
         OP_NOT_FOUND: begin
            res_status_in = ST_NOT_FOUND;
            res_slot_in   = 11'(CAP);
            res_value_in  = '0;
         end
         OP_FULL: begin
            res_status_in = ST_FULL;
            res_slot_in   = 11'(CAP);
            res_value_in  = '0;
         end
         OP_INSERT: begin
            count_in      = count_ff + 1'b1;
            res_status_in = ST_INSERTED;
            res_slot_in   = 11'(i_ff);
            res_value_in  = '0;
         end
         OP_WRITE_VAL: begin
            res_status_in = ST_DONE;
            res_slot_in   = 11'(i_ff);
            res_value_in  = val_ff;
         end
         OP_DEL_INIT: j_in = i_ff + 1'b1;
         OP_DEL_STEP: begin
            i_in = i_after;
            j_in = j_after;
         end
         OP_DEL_END: begin
            if (count_ff != '0) count_in = count_ff - 1'b1;
            res_status_in = ST_DONE;
            res_slot_in   = 11'(CAP);
            res_value_in  = '0;
         end
         OP_DONE: begin
            res_status_in = ST_DONE;
            res_slot_in   = 11'(CAP);
            res_value_in  = '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (cmd.op == OP_OUT);

   // Table storage ports.
   always_comb begin
      used_we = (cmd.op == OP_SWEEP) || (cmd.op == OP_INSERT) || (cmd.op == OP_DEL_END);
      used_wa = (cmd.op == OP_SWEEP) ? sweep_ff : i_ff;
      used_wd = (cmd.op == OP_INSERT);
      keys_we = (cmd.op == OP_INSERT) || ((cmd.op == OP_DEL_STEP) && move);
      keys_wd = (cmd.op == OP_INSERT) ? key_ff : key_q_ff;
      vals_we = keys_we || (cmd.op == OP_WRITE_VAL);
      vals_wd = (cmd.op == OP_INSERT)    ? 32'd0  :
                (cmd.op == OP_WRITE_VAL) ? val_ff : val_q_ff;
      rd_en   = (cmd.op == OP_RD_I) || (cmd.op == OP_RD_J);
      rd_a    = (cmd.op == OP_RD_J) ? j_ff : i_ff;
   end

   always_ff @(posedge clock) begin
      if (used_we) used_ff[used_wa] <= used_wd;
      if (keys_we) keys_ff[i_ff] <= keys_wd;
      if (vals_we) vals_ff[i_ff] <= vals_wd;
      if (rd_en) begin
         used_q_ff <= used_ff[rd_a];
         key_q_ff  <= keys_ff[rd_a];
         val_q_ff  <= vals_ff[rd_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      val_ff        <= val_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      if (cmd.op == OP_OUT) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_count_ff  <= 11'(count_ff);
      end
   end

   always_comb begin
      sts.action     = act_ff;
      sts.hash_done  = hash_done;
      sts.used_q     = used_q_ff;
      sts.key_eq     = (key_q_ff == key_ff);
      sts.at_limit   = (count_ff >= COUNT_W'(MAX_ENTRIES));
      sts.walk_end   = (n_ff == '1);
      sts.shift_end  = (j_after == i_after);
      sts.slot_bad   = (32'(slot_ff) >= 32'(CAP));
      sts.sweep_last = (sweep_ff == '1);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_out        = rsp_slot_ff;
   assign rsp_value_out       = rsp_value_ff;
   assign rsp_entry_count_out = rsp_count_ff;

endmodule
`default_nettype wire

@@ rtl/lpht_ctrl.sv @@
`default_nettype none
module lpht_ctrl
   import lpht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_RST_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DISPATCH  = 4'd2;
   localparam logic [3:0] S_HASH_WAIT = 4'd3;
   localparam logic [3:0] S_PROBE_RD  = 4'd4;
   localparam logic [3:0] S_PROBE_CHK = 4'd5;
   localparam logic [3:0] S_SLOT_CHK  = 4'd6;
   localparam logic [3:0] S_DEL_RD    = 4'd7;
   localparam logic [3:0] S_DEL_CHK   = 4'd8;
   localparam logic [3:0] S_DEL_HASH  = 4'd9;
   localparam logic [3:0] S_DEL_STEP  = 4'd10;
   localparam logic [3:0] S_DEL_FIN   = 4'd11;
   localparam logic [3:0] S_SWEEP     = 4'd12;
   localparam logic [3:0] S_CLR_DONE  = 4'd13;
   localparam logic [3:0] S_RESP      = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       is_lookup;

   assign is_lookup = (sts.action == ACT_LOOKUP);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_RST_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.action)
               ACT_LOOKUP: begin
                  cmd.op   = OP_HASH_KEY;
                  state_in = S_HASH_WAIT;
               end
               ACT_INSERT: begin
                  if (sts.at_limit) begin
                     cmd.op   = OP_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_HASH_KEY;
                     state_in = S_HASH_WAIT;
                  end
               end
               ACT_DELETE, ACT_WRITE: begin
                  if (sts.slot_bad) begin
                     cmd.op   = OP_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     cmd.op   = OP_RD_I;
                     state_in = S_SLOT_CHK;
                  end
               end
               ACT_CLEAR: state_in = S_SWEEP;
               default: begin
                  cmd.op   = OP_DONE;
                  state_in = S_RESP;
               end
            endcase
         end
         S_HASH_WAIT: begin
            if (sts.hash_done) begin
               cmd.op   = OP_PROBE_INIT;
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            cmd.op   = OP_RD_I;
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            state_in = S_RESP;
            if (!sts.used_q) begin
               cmd.op = is_lookup ? OP_NOT_FOUND : OP_INSERT;
            end else if (sts.key_eq) begin
               cmd.op = OP_HIT;
            end else if (sts.walk_end) begin
               cmd.op = is_lookup ? OP_NOT_FOUND : OP_FULL;
            end else begin
               cmd.op   = OP_PROBE_NEXT;
               state_in = S_PROBE_RD;
            end
         end
         S_SLOT_CHK: begin
            if (!sts.used_q) begin
               cmd.op   = OP_NOT_FOUND;
               state_in = S_RESP;
            end else if (sts.action == ACT_WRITE) begin
               cmd.op   = OP_WRITE_VAL;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_DEL_INIT;
               state_in = S_DEL_RD;
            end
         end
         S_DEL_RD: begin
            cmd.op   = OP_RD_J;
            state_in = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            if (!sts.used_q) begin
               cmd.op   = OP_DEL_END;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_HASH_Q;
               state_in = S_DEL_HASH;
            end
         end
         S_DEL_HASH: begin
            if (sts.hash_done) state_in = S_DEL_STEP;
         end
         S_DEL_STEP: begin
            cmd.op   = OP_DEL_STEP;
            state_in = sts.shift_end ? S_DEL_FIN : S_DEL_RD;
         end
         S_DEL_FIN: begin
            cmd.op   = OP_DEL_END;
            state_in = S_RESP;
         end
         S_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (sts.sweep_last) state_in = S_CLR_DONE;
         end
         S_CLR_DONE: begin
            cmd.op   = OP_DONE;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/linear_probe_hash_table_unit.sv @@
`default_nettype none
// Open-addressing hash table of 1024 slots with 32-bit keys and values. Keys
// are hashed with FNV-1a, one byte per cycle, followed by a Fibonacci multiply,
// and collisions are resolved by linear probing; delete closes the gap by
// backward shift. One request is worked on at a time. In a lookup or insert
// each probe is a registered read of the slot store followed by a compare. A
// delete must rehash every following entry of its cluster. Clear walks the
// whole valid map, one slot per cycle. After reset the same clearing pass runs
// before the first request is accepted (req_ready stays low). The finished
// response sits in an output register, so the next request may be taken while
// it waits.
module linear_probe_hash_table_unit
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_key,
   input  wire logic [9:0]  req_slot,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [10:0]      rsp_slot_out,
   output logic [31:0]      rsp_value_out,
   output logic [10:0]      rsp_entry_count_out
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each request; the datapath holds the table.
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpht_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_key             (req_key),
      .req_slot            (req_slot),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_out        (rsp_slot_out),
      .rsp_value_out       (rsp_value_out),
      .rsp_entry_count_out (rsp_entry_count_out)
   );

   // The clearing pass must hold off requests straight after reset.
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // The load limit must never be exceeded.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count_out <= 11'(MAX_ENTRIES)))
      else $error("entry count above load limit");

   // An inserted or found request always names a real slot.
   a_slot_real: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == ST_INSERTED) || (rsp_status == ST_FOUND)))
      |-> (rsp_slot_out < 11'(CAP)))
      else $error("found or inserted response without a slot");

endmodule
`default_nettype wire
